// ===== rtl/core/kgf_pkg.sv =====
// Shared types, codes and defaults of the gray Kuwahara filter.
package kgf_pkg;

    localparam int unsigned DEF_MAX_RADIUS = 4;
    localparam int unsigned DEF_MAX_WIDTH  = 1024;

    localparam int unsigned WIDTH_BITS     = 11;
    localparam int unsigned HEIGHT_BITS    = 13;
    localparam int unsigned RADIUS_BITS    = 3;
    localparam int unsigned CFG_DATA_BITS  = 13;
    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [RADIUS_BITS-1:0] RESET_RADIUS = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       end_of_line;
        logic       end_of_frame;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_VAR_MUL,
        ST_VAR_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/kgf_stream_if.sv =====
// Valid/ready stream channel carrying one request per handshake.
interface kgf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/kgf_ram.sv =====
// Generic single-port RAM with registered read.
module kgf_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/kuwahara_gray_filter_core.sv =====
// Top level of the streaming gray Kuwahara filter.
//
// Gray pixels enter in raster order on src; each filtered pixel leaves on dst
// with end-of-line and end-of-frame marks, r*W+r requests after its own pixel.
// Flush requests (cmd=1) drain the outputs left once the frame is complete.
// All pixel history sits in one single-port line store of
// 2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+1 bytes, which is never cleared.
// A request that yields no result leaves the sequencer in IDLE. A request that
// yields a result passes through CALC, VAR_MUL/VAR_CMP, DIV and OUT: the store's
// one read port fetches the 4*(r+1)^2 quadrant pixels one per cycle, then four
// variance steps (VAR_MUL then VAR_CMP each) and an eight-step restoring divide
// follow. One request is in work at a time; a finished result waits in the output
// register while the next request is taken. After reset and after each register
// write, src is held off while the derived frame constants settle.
module kuwahara_gray_filter_core
    import kgf_pkg::*;
#(
    parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    kgf_stream_if.sink                src,
    kgf_stream_if.source              dst
);
    // widths
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW    = HEIGHT_BITS;
    localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
    localparam int unsigned DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned LW    = WW + HW;
    localparam int unsigned CW    = LW + 1;
    localparam int unsigned NMAX  = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
    localparam int unsigned NW    = $clog2(NMAX + 1);
    localparam int unsigned SW    = $clog2(NMAX * 255 + 1);
    localparam int unsigned QW    = $clog2(NMAX * 65025 + 1);
    localparam int unsigned VW    = (NW + QW > 2 * SW) ? NW + QW : 2 * SW;
    localparam int unsigned OW    = WW + RW + 3;
    localparam int unsigned DW    = NW + 8;

    // configuration and derived frame constants
    logic [WIDTH_BITS-1:0]  cfg_width_reg;
    logic [HEIGHT_BITS-1:0] cfg_height_reg;
    logic [RADIUS_BITS-1:0] cfg_radius_reg;
    logic [1:0]             cfg_hold_reg;
    logic [WW-1:0]          w_reg;
    logic [HW-1:0]          h_reg;
    logic [RW-1:0]          r_reg;
    logic [NW-1:0]          n_reg;
    logic [LW-1:0]          total_reg;
    logic [LW-1:0]          delay_reg;

    // raster position
    logic [WW-1:0] in_col_reg, out_col_reg;
    logic [HW-1:0] in_row_reg, out_row_reg;
    logic [LW-1:0] in_lin_reg, out_lin_reg;
    logic [AW-1:0] in_addr_reg, out_addr_reg;

    state_t state_reg, state_next;

    // fetch sequencer and pipeline
    logic          issue_on_reg;
    logic [1:0]    q_reg;
    logic [RW-1:0] dy_reg, dx_reg;
    logic          p1_valid_reg, p1_last_reg;
    logic [1:0]    p1_q_reg;
    logic signed [OW-1:0] p1_off_reg;
    logic          p2_valid_reg, p2_last_reg;
    logic [1:0]    p2_q_reg;

    // quadrant statistics
    logic [SW-1:0] acc_sum_reg;
    logic [QW-1:0] acc_sq_reg;
    logic [SW-1:0] sum_q_reg [4];
    logic [QW-1:0] sq_q_reg  [4];
    logic [1:0]    vq_reg;
    logic [VW-1:0] nsq_reg, ssq_reg, best_var_reg;
    logic [SW-1:0] vsum_reg, best_sum_reg;
    logic [SW-1:0] rem_reg;
    logic [7:0]    quo_reg;
    logic [2:0]    div_step_reg;

    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic [7:0]  ram_rdata;
    logic [AW-1:0] ram_addr;

    // request handshake
    logic accept, write_en, fire, load_out, last_elem;
    logic [CW-1:0] in_lin_upd, out_thresh;

    assign src.ready = (state_reg == ST_IDLE) && (cfg_hold_reg == 2'b00);
    assign accept    = src.valid && src.ready;
    assign write_en  = accept && (src.data.cmd == CMD_PIXEL) && (in_row_reg < h_reg);
    assign in_lin_upd = CW'(in_lin_reg) + CW'(write_en);
    assign out_thresh = CW'(out_lin_reg) + CW'(delay_reg) + CW'(1);
    assign fire = (out_row_reg < h_reg)
               && ((in_lin_upd >= CW'(total_reg)) || (in_lin_upd >= out_thresh));
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || dst.ready);
    assign last_elem = (dx_reg == r_reg) && (dy_reg == r_reg);

    assign dst.valid = out_valid_reg;
    assign dst.data  = out_item_reg;

    // quadrant origin: upper-left, lower-left, upper-right, lower-right
    logic sel_x, sel_y;
    logic signed [WW+1:0] xs, xc, dx_off;
    logic signed [HW+1:0] ys, yc, dy_off;
    logic signed [RW+1:0] dx_s, dy_s;
    logic signed [OW-1:0] dy_ext, dx_ext, w_ext, off_next;

    always_comb
    begin
        sel_x = ~q_reg[1];
        sel_y = ~q_reg[0];
        xs = $signed((WW+2)'(out_col_reg)) - $signed((WW+2)'(sel_x ? r_reg : '0))
           + $signed((WW+2)'(dx_reg));
        ys = $signed((HW+2)'(out_row_reg)) - $signed((HW+2)'(sel_y ? r_reg : '0))
           + $signed((HW+2)'(dy_reg));
        if (xs < 0)
            xc = '0;
        else if (xs > $signed((WW+2)'(w_reg)) - 1)
            xc = $signed((WW+2)'(w_reg)) - $signed((WW+2)'(1));
        else
            xc = xs;
        if (ys < 0)
            yc = '0;
        else if (ys > $signed((HW+2)'(h_reg)) - 1)
            yc = $signed((HW+2)'(h_reg)) - $signed((HW+2)'(1));
        else
            yc = ys;
        dx_off = xc - $signed((WW+2)'(out_col_reg));
        dy_off = yc - $signed((HW+2)'(out_row_reg));
        dx_s   = dx_off[RW+1:0];
        dy_s   = dy_off[RW+1:0];
        dx_ext = OW'(dx_s);
        dy_ext = OW'(dy_s);
        w_ext  = $signed(OW'(w_reg));
        off_next = dy_ext * w_ext + dx_ext;
    end

    // ring address of the fetched pixel, relative to the output pixel
    logic signed [AW+1:0] rd_sum, rd_wrap;

    always_comb
    begin
        rd_sum = $signed((AW+2)'(out_addr_reg)) + (AW+2)'(p1_off_reg);
        if (rd_sum < 0)
            rd_wrap = rd_sum + $signed((AW+2)'(DEPTH));
        else if (rd_sum >= $signed((AW+2)'(DEPTH)))
            rd_wrap = rd_sum - $signed((AW+2)'(DEPTH));
        else
            rd_wrap = rd_sum;
        ram_addr = (state_reg == ST_IDLE) ? in_addr_reg : rd_wrap[AW-1:0];
    end

    kgf_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (write_en),
        .addr  (ram_addr),
        .wdata (src.data.pixel_in),
        .rdata (ram_rdata)
    );

    // accumulate, variance and divide arithmetic
    logic [SW-1:0] sum_t;
    logic [QW-1:0] sq_t;
    logic [VW-1:0] var_cur;
    logic          take;
    logic [SW-1:0] sel_sum;
    logic [DW-1:0] trial, rem_ext;
    logic          fits;

    always_comb
    begin
        sum_t   = acc_sum_reg + SW'(ram_rdata);
        sq_t    = acc_sq_reg + QW'(ram_rdata) * QW'(ram_rdata);
        var_cur = nsq_reg - ssq_reg;
        take    = (vq_reg == 2'd0) || (var_cur < best_var_reg);
        sel_sum = take ? vsum_reg : best_sum_reg;
        trial   = DW'(n_reg) << div_step_reg;
        rem_ext = DW'(rem_reg);
        fits    = rem_ext >= trial;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && fire)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (p2_valid_reg && p2_last_reg && (p2_q_reg == 2'd3))
                    state_next = ST_VAR_MUL;
            end
            ST_VAR_MUL:
            begin
                state_next = ST_VAR_CMP;
            end
            ST_VAR_CMP:
            begin
                state_next = (vq_reg == 2'd3) ? ST_DIV : ST_VAR_MUL;
            end
            ST_DIV:
            begin
                if (div_step_reg == 3'd0)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    logic          out_eol, out_eof;
    logic [WW:0]   in_col_inc, out_col_inc;

    assign in_col_inc  = (WW+1)'(in_col_reg) + (WW+1)'(1);
    assign out_col_inc = (WW+1)'(out_col_reg) + (WW+1)'(1);
    assign out_eol = (out_col_reg == w_reg - WW'(1));
    assign out_eof = out_eol && (out_row_reg == h_reg - HW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= RESET_WIDTH;
            cfg_height_reg <= RESET_HEIGHT;
            cfg_radius_reg <= RESET_RADIUS;
            cfg_hold_reg   <= 2'b11;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_lin_reg     <= '0;
            in_addr_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_lin_reg    <= '0;
            out_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            issue_on_reg   <= 1'b0;
            q_reg          <= '0;
            dy_reg         <= '0;
            dx_reg         <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            vq_reg         <= '0;
            div_step_reg   <= '0;
        end
        else
        begin
            // src held off while clamped values settle first, products after them
            cfg_hold_reg <= cfg_we ? 2'b11 : {1'b0, cfg_hold_reg[1]};
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                    CFG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                    CFG_RADIUS:       cfg_radius_reg <= cfg_data[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end

            // a register write or the last output of a frame restarts the frame
            if ((cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT
                            || cfg_index == CFG_RADIUS))
                || (load_out && out_eof))
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_lin_reg   <= '0;
                in_addr_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_lin_reg  <= '0;
                out_addr_reg <= '0;
            end
            else
            begin
                if (write_en)
                begin
                    in_lin_reg  <= in_lin_reg + LW'(1);
                    in_addr_reg <= (in_addr_reg == AW'(DEPTH - 1)) ? '0 : in_addr_reg + AW'(1);
                    if (in_col_inc >= (WW+1)'(w_reg))
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + HW'(1);
                    end
                    else
                        in_col_reg <= in_col_inc[WW-1:0];
                end
                if (load_out)
                begin
                    out_lin_reg  <= out_lin_reg + LW'(1);
                    out_addr_reg <= (out_addr_reg == AW'(DEPTH - 1)) ? '0
                                  : out_addr_reg + AW'(1);
                    if (out_col_inc >= (WW+1)'(w_reg))
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + HW'(1);
                    end
                    else
                        out_col_reg <= out_col_inc[WW-1:0];
                end
            end

            out_valid_reg <= load_out || (out_valid_reg && !dst.ready);

            // fetch order: quadrant, then row, then column
            if (accept && fire)
            begin
                issue_on_reg <= 1'b1;
                q_reg  <= '0;
                dy_reg <= '0;
                dx_reg <= '0;
            end
            else if (issue_on_reg)
            begin
                if (dx_reg == r_reg)
                begin
                    dx_reg <= '0;
                    if (dy_reg == r_reg)
                    begin
                        dy_reg <= '0;
                        q_reg  <= q_reg + 2'd1;
                        if (q_reg == 2'd3)
                            issue_on_reg <= 1'b0;
                    end
                    else
                        dy_reg <= dy_reg + RW'(1);
                end
                else
                    dx_reg <= dx_reg + RW'(1);
            end
            p1_valid_reg <= issue_on_reg;
            p2_valid_reg <= p1_valid_reg;

            if (state_reg == ST_CALC && state_next == ST_VAR_MUL)
                vq_reg <= '0;
            else if (state_reg == ST_VAR_CMP)
                vq_reg <= vq_reg + 2'd1;

            if (state_reg == ST_VAR_CMP)
                div_step_reg <= 3'd7;
            else if (state_reg == ST_DIV)
                div_step_reg <= div_step_reg - 3'd1;
        end
    end

    // clamped values are registered from the config registers, products from the clamped values
    always_ff @(posedge clk)
    begin
        if (cfg_width_reg == '0)
            w_reg <= WW'(1);
        else if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
            w_reg <= WW'(MAX_WIDTH);
        else
            w_reg <= WW'(cfg_width_reg);
        h_reg <= (cfg_height_reg == '0) ? HW'(1) : cfg_height_reg;
        if (cfg_radius_reg == '0)
            r_reg <= RW'(1);
        else if (32'(cfg_radius_reg) > 32'(MAX_RADIUS))
            r_reg <= RW'(MAX_RADIUS);
        else
            r_reg <= RW'(cfg_radius_reg);
        n_reg     <= NW'((NW+1)'(r_reg) + (NW+1)'(1)) * NW'((NW+1)'(r_reg) + (NW+1)'(1));
        total_reg <= LW'(w_reg) * LW'(h_reg);
        delay_reg <= LW'(r_reg) * LW'(w_reg) + LW'(r_reg);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p1_off_reg  <= off_next;
        p1_q_reg    <= q_reg;
        p1_last_reg <= last_elem;
        p2_q_reg    <= p1_q_reg;
        p2_last_reg <= p1_last_reg;

        if (accept && fire)
        begin
            acc_sum_reg <= '0;
            acc_sq_reg  <= '0;
        end
        else if (p2_valid_reg)
        begin
            if (p2_last_reg)
            begin
                sum_q_reg[p2_q_reg] <= sum_t;
                sq_q_reg[p2_q_reg]  <= sq_t;
                acc_sum_reg <= '0;
                acc_sq_reg  <= '0;
            end
            else
            begin
                acc_sum_reg <= sum_t;
                acc_sq_reg  <= sq_t;
            end
        end

        if (state_reg == ST_VAR_MUL)
        begin
            nsq_reg  <= VW'(n_reg) * VW'(sq_q_reg[vq_reg]);
            ssq_reg  <= VW'(sum_q_reg[vq_reg]) * VW'(sum_q_reg[vq_reg]);
            vsum_reg <= sum_q_reg[vq_reg];
        end

        if (state_reg == ST_VAR_CMP)
        begin
            if (take)
            begin
                best_var_reg <= var_cur;
                best_sum_reg <= vsum_reg;
            end
            rem_reg <= sel_sum;
        end
        else if (state_reg == ST_DIV)
        begin
            if (fits)
                rem_reg <= SW'(rem_ext - trial);
            quo_reg[div_step_reg] <= fits;
        end

        if (load_out)
        begin
            out_item_reg.pixel_out    <= quo_reg;
            out_item_reg.end_of_line  <= out_eol;
            out_item_reg.end_of_frame <= out_eof;
        end
    end

`ifndef ASSERT_OFF
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !src.ready)
        else $error("input taken while a request is in work");

    a_fetch_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> (state_reg == ST_CALC))
        else $error("store data returned outside the fetch phase");

    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_addr_reg < AW'(DEPTH)) && (in_addr_reg < AW'(DEPTH)))
        else $error("ring pointer beyond the line store");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("finished result not held in the output register");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the streaming gray Kuwahara filter core.
`default_nettype none

module testbench
    import kgf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Ring depth of the pixel history: 2*MAX_RADIUS lines plus one window.
    localparam int RING_DEPTH = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;
    localparam int SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    kgf_stream_if #(.payload_t(in_item_t))  src_if ();
    kgf_stream_if #(.payload_t(out_item_t)) dst_if ();

    kuwahara_gray_filter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src_if.sink),
        .dst       (dst_if.source)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the pixel ring, the raster
    // counters and the three registers.
    // ---------------------------------------------------------------
    logic [7:0]  pixel_ring [RING_DEPTH];
    logic [10:0] width_reg  = RESET_WIDTH;
    logic [12:0] height_reg = RESET_HEIGHT;
    logic [2:0]  radius_reg = RESET_RADIUS;
    int unsigned wr_col, wr_row, rd_col, rd_row;

    in_item_t  pending_requests [$];   // requests waiting for the driver
    out_item_t filtered_pixels  [$];   // predicted outputs not yet seen
    int        mismatches = 0;
    longint    cycle_count = 0;
    int        send_idle_pct = 7;      // percent of cycles the source holds back
    int        recv_stall_pct = 75;    // percent of cycles the sink holds ready low
    bit        src_taken = 1'b0;

    function automatic int unsigned cur_width();
        if (width_reg == 0) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned cur_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic int unsigned cur_radius();
        if (radius_reg == 0) return 1;
        if (radius_reg > DEF_MAX_RADIUS) return DEF_MAX_RADIUS;
        return radius_reg;
    endfunction

    function automatic int clamp_pos(int v, int lim);
        if (v < 0) return 0;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    // Least-variance quadrant mean at (x,y); quadrant order UL, LL, UR, LR,
    // the earliest wins a tie.
    function automatic logic [7:0] quadrant_mean(int x, int y, int w, int h, int r);
        int     qx [4];
        int     qy [4];
        longint n, sum, sq, var_q, best_var, best_sum;
        int     yy, xx;
        longint p;
        qx = '{1, 1, 0, 0};
        qy = '{1, 0, 1, 0};
        n = (r + 1) * (r + 1);
        best_var = 0;
        best_sum = 0;
        for (int q = 0; q < 4; q++)
        begin
            sum = 0;
            sq = 0;
            for (int dy = 0; dy <= r; dy++)
            begin
                yy = clamp_pos(y - qy[q] * r + dy, h);
                for (int dx = 0; dx <= r; dx++)
                begin
                    xx = clamp_pos(x - qx[q] * r + dx, w);
                    p = pixel_ring[(yy * w + xx) % RING_DEPTH];
                    sum += p;
                    sq += p * p;
                end
            end
            var_q = n * sq - sum * sum;
            if (q == 0 || var_q < best_var)
            begin
                best_var = var_q;
                best_sum = sum;
            end
        end
        return 8'(best_sum / n);
    endfunction

    // Advance the predictor by one request; returns 1 when it yields a pixel.
    function automatic bit filter_request(in_item_t req, output out_item_t res);
        int unsigned w, h, r, total, delay, in_lin, out_lin;
        w = cur_width();
        h = cur_height();
        r = cur_radius();
        total = w * h;
        delay = r * w + r;
        res = '0;
        in_lin = wr_row * w + wr_col;
        if (req.cmd == CMD_PIXEL && wr_row < h)
        begin
            pixel_ring[in_lin % RING_DEPTH] = req.pixel_in;
            in_lin++;
            wr_col++;
            if (wr_col >= w)
            begin
                wr_col = 0;
                wr_row++;
            end
        end
        if (rd_row >= h) return 1'b0;
        out_lin = rd_row * w + rd_col;
        if (!(in_lin >= total || in_lin >= out_lin + delay + 1)) return 1'b0;
        res.pixel_out = quadrant_mean(rd_col, rd_row, w, h, r);
        res.end_of_line = (rd_col == w - 1);
        res.end_of_frame = res.end_of_line && (rd_row == h - 1);
        rd_col++;
        if (rd_col >= w)
        begin
            rd_col = 0;
            rd_row++;
        end
        if (rd_row >= h)
        begin
            wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: check outputs first (they belong to older requests), then
    // run the predictor on an accepted request.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t exp_px;
        out_item_t got_px;
        out_item_t new_px;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            src_taken = src_if.valid && src_if.ready;
            if (dst_if.valid && dst_if.ready)
            begin
                got_px = dst_if.data;
                if (filtered_pixels.size() == 0)
                begin
                    $error("unexpected output pixel %0d", got_px.pixel_out);
                    mismatches++;
                end
                else
                begin
                    exp_px = filtered_pixels.pop_front();
                    if (got_px.pixel_out !== exp_px.pixel_out)
                    begin
                        $error("pixel_out expected %0d got %0d",
                               exp_px.pixel_out, got_px.pixel_out);
                        mismatches++;
                    end
                    if (got_px.end_of_line !== exp_px.end_of_line)
                    begin
                        $error("end_of_line expected %0d got %0d",
                               exp_px.end_of_line, got_px.end_of_line);
                        mismatches++;
                    end
                    if (got_px.end_of_frame !== exp_px.end_of_frame)
                    begin
                        $error("end_of_frame expected %0d got %0d",
                               exp_px.end_of_frame, got_px.end_of_frame);
                        mismatches++;
                    end
                end
            end
            if (src_taken && filter_request(src_if.data, new_px))
                filtered_pixels = {filtered_pixels, new_px};
        end
    end

    // ---------------------------------------------------------------
    // Driver: source and sink change on the falling edge only.
    // ---------------------------------------------------------------
    initial
    begin
        src_if.valid = 1'b0;
        src_if.data = '0;
        dst_if.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!src_if.valid || src_taken)
            begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    src_if.data <= pending_requests.pop_front();
                    src_if.valid <= 1'b1;
                end
                else
                    src_if.valid <= 1'b0;
            end
            dst_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            src_taken = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic wait_idle();
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (src_if.valid || filtered_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; the block and the predictor both restart the frame.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_BITS'(val);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg = 11'(val);
            CFG_IMAGE_HEIGHT: height_reg = 13'(val);
            default:          radius_reg = 3'(val);
        endcase
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned r);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_RADIUS, r);
    endtask

    // Pixel content styles: full range, black/white only, narrow band (ties).
    function automatic logic [7:0] pick_pixel(int style);
        case (style)
            0:       return 8'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(100, 103));
        endcase
    endfunction

    task automatic push_request(logic cmd, logic [7:0] px);
        in_item_t req;
        req.cmd = cmd;
        req.pixel_in = px;
        pending_requests = {pending_requests, req};
    endtask

    // One frame of pixels with occasional flush requests mixed in, then
    // enough flush requests (some sent as surplus pixels) to drain it.
    task automatic send_frame(int unsigned n_pix, int unsigned drain, output int sent);
        int style;
        style = $urandom_range(0, 2);
        sent = 0;
        for (int i = 0; i < n_pix; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_request(CMD_FLUSH, 8'($urandom_range(0, 255)));
                sent++;
            end
            push_request(CMD_PIXEL, pick_pixel(style));
            sent++;
        end
        for (int i = 0; i < drain; i++)
        begin
            push_request($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_FLUSH,
                         8'($urandom_range(0, 255)));
            sent++;
        end
    endtask

    initial
    begin
        int sent, total_sent, w, h, r, eff_r, phase;
        cfg_we = 1'b0;
        for (int i = 0; i < RING_DEPTH; i++)
            pixel_ring[i] = 8'h00;
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero registers read as 1x1 with radius 1
        configure(0, 0, 0);
        push_request(CMD_PIXEL, 8'hFF);
        push_request(CMD_FLUSH, 8'h00);
        push_request(CMD_PIXEL, 8'h00);

        // Oversized radius saturates; short line, outputs after the first come from flushes
        configure(20, 1, 7);
        for (int i = 0; i < 20; i++)
            push_request(CMD_PIXEL, (i % 3 == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
        for (int i = 0; i < 24; i++)
            push_request(CMD_FLUSH, 8'hFF);

        // Tallest frame: one column, left partly done before the next write
        configure(1, 4096, 1);
        for (int i = 0; i < 20; i++)
            push_request(CMD_PIXEL, 8'(i * 13));

        // Surplus pixel after the frame's input acts as a flush; tie on flat input
        configure(3, 2, 2);
        for (int i = 0; i < 6; i++)
            push_request(CMD_PIXEL, 8'd77);
        for (int i = 0; i < 8; i++)
            push_request(CMD_PIXEL, 8'd200);
        push_request(CMD_FLUSH, 8'd0);

        // Random frames under three idling regimes
        total_sent = 0;
        phase = 0;
        while (total_sent < 650)
        begin
            if (phase < 3 && total_sent >= 250 * phase)
            begin
                if (phase == 0)      begin send_idle_pct = 7;  recv_stall_pct = 75; end
                else if (phase == 1) begin send_idle_pct = 75; recv_stall_pct = 7;  end
                else                 begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                phase++;
            end
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 8);
            r = $urandom_range(0, 7);
            configure(w, h, r);
            eff_r = (r == 0) ? 1 : (r > 4 ? 4 : r);
            // Usually a whole frame, sometimes two back to back, sometimes cut short
            for (int f = 0; f < ($urandom_range(0, 3) == 0 ? 2 : 1); f++)
            begin
                send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, (w == 0 ? 1 : w) * (h == 0 ? 1 : h))
                                                       : (w == 0 ? 1 : w) * (h == 0 ? 1 : h),
                           eff_r * (w == 0 ? 1 : w) + eff_r + 3, sent);
                total_sent += sent;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
